### src/pn3o_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn3o_pkg: shared types and constants for the 3D octave Perlin noise unit
// Controller states, command/status bundles, sequencer slot codes.
// ----------------------------------------------------------------------------
package pn3o_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int COORD_W   = 24;
    localparam int CELL_W    = 8;
    localparam int OUT_W     = 17;
    localparam int OUT_FRAC  = 16;
    localparam int OCT_CFG_W = 4;

    localparam logic [OCT_CFG_W-1:0] OCT_CFG_RESET = 4'd4;

    // action codes carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // gradient selection codes
    localparam logic [3:0] HASH_U_Y   = 4'd8;
    localparam logic [3:0] HASH_V_ZX  = 4'd4;
    localparam logic [3:0] HASH_V_X_A = 4'd12;
    localparam logic [3:0] HASH_V_X_B = 4'd14;

    typedef logic [3:0] slot_t;

    // permutation read slots, in issue order
    localparam slot_t RD_X   = 4'd0;
    localparam slot_t RD_X1  = 4'd1;
    localparam slot_t RD_A   = 4'd2;
    localparam slot_t RD_A1  = 4'd3;
    localparam slot_t RD_B   = 4'd4;
    localparam slot_t RD_B1  = 4'd5;
    localparam slot_t RD_AA  = 4'd6;
    localparam slot_t RD_BA  = 4'd7;
    localparam slot_t RD_AB  = 4'd8;
    localparam slot_t RD_BB  = 4'd9;
    localparam slot_t RD_AA1 = 4'd10;
    localparam slot_t RD_BA1 = 4'd11;
    localparam slot_t RD_AB1 = 4'd12;
    localparam slot_t RD_BB1 = 4'd13;

    // capture slots (each captured in the cycle after its read)
    localparam slot_t CAP_A  = 4'd0;
    localparam slot_t CAP_B  = 4'd1;
    localparam slot_t CAP_AA = 4'd2;
    localparam slot_t CAP_AB = 4'd3;
    localparam slot_t CAP_BA = 4'd4;
    localparam slot_t CAP_BB = 4'd5;
    localparam slot_t CAP_H0 = 4'd6;
    localparam slot_t CAP_H7 = 4'd13;

    localparam slot_t HASH_LAST = 4'd14;

    // multiplier slots: fades, then the lerp tree
    localparam slot_t MS_X2 = 4'd0;
    localparam slot_t MS_X3 = 4'd1;
    localparam slot_t MS_XF = 4'd2;
    localparam slot_t MS_Y2 = 4'd3;
    localparam slot_t MS_Y3 = 4'd4;
    localparam slot_t MS_YF = 4'd5;
    localparam slot_t MS_Z2 = 4'd6;
    localparam slot_t MS_Z3 = 4'd7;
    localparam slot_t MS_ZF = 4'd8;
    localparam slot_t MS_L0 = 4'd9;
    localparam slot_t MS_L1 = 4'd10;
    localparam slot_t MS_L2 = 4'd11;
    localparam slot_t MS_L3 = 4'd12;
    localparam slot_t MS_M0 = 4'd13;
    localparam slot_t MS_M1 = 4'd14;
    localparam slot_t MS_N  = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_GRAD,
        ST_MUL,
        ST_ACC,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PH_PREP,
        PH_MUL,
        PH_WB
    } phase_t;

    typedef struct packed {
        logic  start;
        logic  load_en;
        logic  rd_en;
        slot_t rd_slot;
        logic  cap_en;
        slot_t cap_slot;
        logic  grad_en;
        logic  prep_en;
        logic  mul_en;
        logic  wb_en;
        slot_t mslot;
        logic  acc_en;
        logic  fin_en;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

### src/perlin_noise_3d_octaves_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves_unit: 3D improved Perlin noise summed over octaves
// Streaming noise evaluator with a loadable 256-byte permutation table.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_*: tuser = 0 loads one permutation byte (no result),
//   tuser = 1 evaluates noise at (x, y, z) and yields one result word on m_*.
//   cfg_wr_en/cfg_wr_data set the octave count (0..15, above MAX_OCTAVES
//   saturates); write it only while the unit is idle.
// Sequence:
//   A load word is written while idle. An evaluate word occupies the unit for
//   n octaves: each runs the permutation reads on the single memory port, a
//   gradient step, 16 multiplier slots (prep, multiply, write back) on the one
//   shared multiplier and an accumulate step, then a final step. The result
//   word appears the cycle after the final step.
// Reset:
//   aresetn clears the valid bits of the table at once, so every entry reads
//   as its own index, and sets the octave count to 4.
// Back-pressure:
//   The result sits in an output register; the unit accepts the next word
//   while it waits. A second result holds in its final step until m_tready.
// ----------------------------------------------------------------------------
module perlin_noise_3d_octaves_unit
    import pn3o_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [OCT_CFG_W-1:0] cfg_wr_data,   // octave_count
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [7:0] table_index, [15:8] table_value, [39:16] coord_x,
    // [63:40] coord_y, [87:64] coord_z, [95:88] zero
    input  wire logic [95:0]          s_tdata,
    input  wire logic [0:0]           s_tuser,       // [0] action
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata        // [16:0] noise_value, [23:17] zero
);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [OUT_W-1:0] noise_value;

    pn3o_ctrl #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_tvalid),
        .in_action  (s_tuser[0]),
        .in_ready   (s_tready),
        .cmd        (cmd),
        .status     (status)
    );

    pn3o_datapath #(
        .MAX_OCTAVES(MAX_OCTAVES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .tbl_index  (s_tdata[7:0]),
        .tbl_value  (s_tdata[15:8]),
        .coord_x_in (s_tdata[39:16]),
        .coord_y_in (s_tdata[63:40]),
        .coord_z_in (s_tdata[87:64]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .noise_value(noise_value)
    );

    assign m_tdata = {7'b0, noise_value};

`ifndef SYNTHESIS
    // an evaluate word leaves the unit not ready in the cycle after it is taken
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == ACT_EVAL) |=> !s_tready)
        else $error("evaluate word did not start the sequencer");

    // a load word never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == ACT_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("load word produced a result");

    // result is clamped to one
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16] == 1'b0) || (m_tdata[15:0] == 16'd0))
        else $error("noise value above one");
`endif

endmodule
`default_nettype wire

### src/pn3o_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn3o_ctrl: sequencer for the octave noise unit
// Walks hash reads, gradient load, multiplier slots and accumulation per octave; also issues loads and the final step.
// ----------------------------------------------------------------------------
module pn3o_ctrl
    import pn3o_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [OCT_CFG_W-1:0] cfg_wr_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_action,
    output logic                      in_ready,
    output dp_cmd_t                   cmd,
    input  wire dp_status_t           status
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    slot_t                  cnt_reg, cnt_next;
    slot_t                  mslot_reg, mslot_next;
    logic [OCT_W-1:0]       oct_reg, oct_next;
    logic [OCT_W-1:0]       noct_reg, noct_next;
    logic [OCT_CFG_W-1:0]   oct_cfg_reg;
    logic [OCT_W-1:0]       n_sat;
    logic [OCT_W-1:0]       oct_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_PREP;
            cnt_reg     <= '0;
            mslot_reg   <= '0;
            oct_reg     <= '0;
            noct_reg    <= '0;
            oct_cfg_reg <= OCT_CFG_RESET;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            mslot_reg <= mslot_next;
            oct_reg   <= oct_next;
            noct_reg  <= noct_next;
            if (cfg_wr_en) begin
                oct_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        if (int'(oct_cfg_reg) > MAX_OCTAVES) begin
            n_sat = OCT_W'(MAX_OCTAVES);
        end else begin
            n_sat = OCT_W'(oct_cfg_reg);
        end
    end

    assign oct_inc = OCT_W'(oct_reg + 1'b1);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mslot_next = mslot_reg;
        oct_next   = oct_reg;
        noct_next  = noct_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mslot  = mslot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_action == ACT_LOAD) begin
                        cmd.load_en = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        noct_next = n_sat;
                        oct_next  = '0;
                        cnt_next  = '0;
                        state_next = (n_sat == '0) ? ST_FINAL : ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                cmd.rd_en    = (cnt_reg != HASH_LAST);
                cmd.rd_slot  = cnt_reg;
                cmd.cap_en   = (cnt_reg != RD_X);
                cmd.cap_slot = slot_t'(cnt_reg - 1'b1);
                if (cnt_reg == HASH_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_GRAD;
                end else begin
                    cnt_next = slot_t'(cnt_reg + 1'b1);
                end
            end
            ST_GRAD: begin
                cmd.grad_en = 1'b1;
                mslot_next  = MS_X2;
                phase_next  = PH_PREP;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                case (phase_reg)
                    PH_PREP: begin
                        cmd.prep_en = 1'b1;
                        phase_next  = PH_MUL;
                    end
                    PH_MUL: begin
                        cmd.mul_en = 1'b1;
                        phase_next = PH_WB;
                    end
                    PH_WB: begin
                        cmd.wb_en  = 1'b1;
                        phase_next = PH_PREP;
                        if (mslot_reg == MS_N) begin
                            state_next = ST_ACC;
                        end else begin
                            mslot_next = slot_t'(mslot_reg + 1'b1);
                        end
                    end
                    default: begin
                        phase_next = PH_PREP;
                    end
                endcase
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                oct_next   = oct_inc;
                cnt_next   = '0;
                state_next = (oct_inc == noct_reg) ? ST_FINAL : ST_HASH;
            end
            ST_FINAL: begin
                if (!status.out_busy) begin
                    cmd.fin_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/pn3o_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pn3o_datapath: permutation memory, shared multiplier and octave accumulator
// Executes the commands issued by pn3o_ctrl; holds the result word register.
// ----------------------------------------------------------------------------
module pn3o_datapath
    import pn3o_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    input  wire logic [CELL_W-1:0]  tbl_index,
    input  wire logic [CELL_W-1:0]  tbl_value,
    input  wire logic [COORD_W-1:0] coord_x_in,
    input  wire logic [COORD_W-1:0] coord_y_in,
    input  wire logic [COORD_W-1:0] coord_z_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [OUT_W-1:0]        noise_value
);

    localparam int VW     = FRAC_BITS + 3;       // signed noise/gradient values
    localparam int AW     = FRAC_BITS + 3;       // multiplier operand A
    localparam int BW     = FRAC_BITS + 4;       // multiplier operand B
    localparam int PW     = AW + BW;
    localparam int RW     = FRAC_BITS + 4;       // rounded product
    localparam int ACC_W  = FRAC_BITS + MAX_OCTAVES + 4;
    localparam int WSH_W  = $clog2(MAX_OCTAVES + 1);
    localparam int TBL_D  = 1 << CELL_W;
    localparam int EXT_W  = COORD_W + CELL_W;
    localparam int SH     = FRAC_BITS + MAX_OCTAVES + 1 - OUT_FRAC;
    localparam int NW     = ACC_W + 8;

    localparam logic signed [VW-1:0] ONE_V   = VW'(1) << FRAC_BITS;
    localparam logic [RW-1:0]        ONE_R   = RW'(1) << FRAC_BITS;
    localparam logic [PW:0]          HALF_P  = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [BW:0]          TEN_ONE = (BW + 1)'(10) << FRAC_BITS;
    localparam logic [ACC_W:0]       BIAS    = (ACC_W + 1)'(1) << (MAX_OCTAVES + FRAC_BITS);
    localparam logic [NW-1:0]        OUT_ONE = NW'(1) << OUT_FRAC;

    function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
                                                  input logic signed [VW-1:0] x,
                                                  input logic signed [VW-1:0] y,
                                                  input logic signed [VW-1:0] z);
        logic signed [VW-1:0] u;
        logic signed [VW-1:0] v;
        u = (h < HASH_U_Y) ? x : y;
        if (h < HASH_V_ZX) begin
            v = y;
        end else if (h == HASH_V_X_A || h == HASH_V_X_B) begin
            v = x;
        end else begin
            v = z;
        end
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    // coordinates and cells
    logic [COORD_W-1:0]   cx_reg, cy_reg, cz_reg;
    logic [EXT_W-1:0]     ext_x, ext_y, ext_z;
    logic [CELL_W-1:0]    cell_x, cell_y, cell_z;
    logic [FRAC_BITS-1:0] fx, fy, fz;

    assign ext_x  = EXT_W'(cx_reg) >> FRAC_BITS;
    assign ext_y  = EXT_W'(cy_reg) >> FRAC_BITS;
    assign ext_z  = EXT_W'(cz_reg) >> FRAC_BITS;
    assign cell_x = ext_x[CELL_W-1:0];
    assign cell_y = ext_y[CELL_W-1:0];
    assign cell_z = ext_z[CELL_W-1:0];
    assign fx     = cx_reg[FRAC_BITS-1:0];
    assign fy     = cy_reg[FRAC_BITS-1:0];
    assign fz     = cz_reg[FRAC_BITS-1:0];

    // permutation memory; entries never loaded read as their index
    logic [CELL_W-1:0] perm_mem [TBL_D];
    logic [TBL_D-1:0]  perm_vld_reg;
    logic [CELL_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            perm_mem[tbl_index] <= tbl_value;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= perm_vld_reg[rd_addr] ? perm_mem[rd_addr] : rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_vld_reg <= '0;
        end else if (cmd.load_en) begin
            perm_vld_reg[tbl_index] <= 1'b1;
        end
    end

    // hash chain
    logic [CELL_W-1:0] a_reg, b_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic [3:0]        hash_reg [8];
    slot_t             hidx;

    always_comb begin
        unique case (cmd.rd_slot)
            RD_X:    rd_addr = cell_x;
            RD_X1:   rd_addr = CELL_W'(cell_x + 1'b1);
            RD_A:    rd_addr = a_reg;
            RD_A1:   rd_addr = CELL_W'(a_reg + 1'b1);
            RD_B:    rd_addr = b_reg;
            RD_B1:   rd_addr = CELL_W'(b_reg + 1'b1);
            RD_AA:   rd_addr = aa_reg;
            RD_BA:   rd_addr = ba_reg;
            RD_AB:   rd_addr = ab_reg;
            RD_BB:   rd_addr = bb_reg;
            RD_AA1:  rd_addr = CELL_W'(aa_reg + 1'b1);
            RD_BA1:  rd_addr = CELL_W'(ba_reg + 1'b1);
            RD_AB1:  rd_addr = CELL_W'(ab_reg + 1'b1);
            RD_BB1:  rd_addr = CELL_W'(bb_reg + 1'b1);
            default: rd_addr = cell_x;
        endcase
    end

    assign hidx = slot_t'(cmd.cap_slot - CAP_H0);

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            case (cmd.cap_slot) inside
                CAP_A:  a_reg  <= CELL_W'(rd_data_reg + cell_y);
                CAP_B:  b_reg  <= CELL_W'(rd_data_reg + cell_y);
                CAP_AA: aa_reg <= CELL_W'(rd_data_reg + cell_z);
                CAP_AB: ab_reg <= CELL_W'(rd_data_reg + cell_z);
                CAP_BA: ba_reg <= CELL_W'(rd_data_reg + cell_z);
                CAP_BB: bb_reg <= CELL_W'(rd_data_reg + cell_z);
                [CAP_H0:CAP_H7]: hash_reg[hidx[2:0]] <= rd_data_reg[3:0];
                default: ;
            endcase
        end
    end

    // corner gradients: bit 0 of the corner selects x-1, bit 1 y-1, bit 2 z-1
    logic signed [VW-1:0] fxv, fyv, fzv, fxm, fym, fzm;
    logic signed [VW-1:0] g_reg [8];

    assign fxv = $signed({3'b000, fx});
    assign fyv = $signed({3'b000, fy});
    assign fzv = $signed({3'b000, fz});
    assign fxm = fxv - ONE_V;
    assign fym = fyv - ONE_V;
    assign fzm = fzv - ONE_V;

    always_ff @(posedge aclk) begin
        if (cmd.grad_en) begin
            for (int k = 0; k < 8; k++) begin
                g_reg[k] <= grad(hash_reg[k],
                                 k[0] ? fxm : fxv,
                                 k[1] ? fym : fyv,
                                 k[2] ? fzm : fzv);
            end
        end
    end

    // shared multiplier: prep, multiply, write back
    logic [FRAC_BITS:0]   t2_reg, t3_reg, fu_reg, fv_reg, fw_reg;
    logic signed [VW-1:0] lr_reg [7];
    logic [FRAC_BITS-1:0] tf;
    logic [BW:0]          p_w;
    logic signed [VW-1:0] base_sel, other_sel;
    logic [FRAC_BITS:0]   ts_sel;
    logic signed [VW:0]   diff;
    logic [VW:0]          diff_mag;
    logic [AW-1:0]        opa_n, opa_reg;
    logic [BW-1:0]        opb_n, opb_reg;
    logic                 neg_n, neg_reg;
    logic signed [VW-1:0] base_reg;
    logic [PW-1:0]        prod_reg;
    logic [PW:0]          rsum;
    logic [RW-1:0]        rval;
    logic [FRAC_BITS:0]   fclamp;
    logic signed [VW+1:0] rsg, lsum;
    slot_t                lidx;

    always_comb begin
        case (cmd.mslot) inside
            MS_Y2, MS_Y3, MS_YF: tf = fy;
            MS_Z2, MS_Z3, MS_ZF: tf = fz;
            default:             tf = fx;
        endcase
    end

    // p = 6*t2 - 15*t + 10
    assign p_w = ((BW + 1)'(t2_reg) << 2) + ((BW + 1)'(t2_reg) << 1) + TEN_ONE
               - (((BW + 1)'(tf) << 4) - (BW + 1)'(tf));

    always_comb begin
        unique case (cmd.mslot)
            MS_L1: begin
                base_sel = g_reg[2]; other_sel = g_reg[3]; ts_sel = fu_reg;
            end
            MS_L2: begin
                base_sel = g_reg[4]; other_sel = g_reg[5]; ts_sel = fu_reg;
            end
            MS_L3: begin
                base_sel = g_reg[6]; other_sel = g_reg[7]; ts_sel = fu_reg;
            end
            MS_M0: begin
                base_sel = lr_reg[0]; other_sel = lr_reg[1]; ts_sel = fv_reg;
            end
            MS_M1: begin
                base_sel = lr_reg[2]; other_sel = lr_reg[3]; ts_sel = fv_reg;
            end
            MS_N: begin
                base_sel = lr_reg[4]; other_sel = lr_reg[5]; ts_sel = fw_reg;
            end
            default: begin
                base_sel = g_reg[0]; other_sel = g_reg[1]; ts_sel = fu_reg;
            end
        endcase
    end

    assign diff     = (VW + 1)'(other_sel) - (VW + 1)'(base_sel);
    assign diff_mag = diff[VW] ? (VW + 1)'(-diff) : (VW + 1)'(diff);

    always_comb begin
        neg_n = 1'b0;
        unique case (cmd.mslot) inside
            MS_X2, MS_Y2, MS_Z2: begin
                opa_n = AW'(tf);
                opb_n = BW'(tf);
            end
            MS_X3, MS_Y3, MS_Z3: begin
                opa_n = AW'(t2_reg);
                opb_n = BW'(tf);
            end
            MS_XF, MS_YF, MS_ZF: begin
                opa_n = AW'(t3_reg);
                opb_n = p_w[BW-1:0];
            end
            default: begin
                opa_n = diff_mag[AW-1:0];
                opb_n = BW'(ts_sel);
                neg_n = diff[VW];
            end
        endcase
    end

    assign rsum   = {1'b0, prod_reg} + HALF_P;
    assign rval   = rsum[FRAC_BITS+RW-1:FRAC_BITS];
    assign fclamp = (rval > ONE_R) ? ONE_R[FRAC_BITS:0] : rval[FRAC_BITS:0];
    assign rsg    = $signed((VW + 2)'(rval));
    assign lsum   = neg_reg ? (VW + 2)'(base_reg) - rsg : (VW + 2)'(base_reg) + rsg;
    assign lidx   = slot_t'(cmd.mslot - MS_L0);

    always_ff @(posedge aclk) begin
        if (cmd.prep_en) begin
            opa_reg  <= opa_n;
            opb_reg  <= opb_n;
            neg_reg  <= neg_n;
            base_reg <= base_sel;
        end
        if (cmd.mul_en) begin
            prod_reg <= opa_reg * opb_reg;
        end
        if (cmd.wb_en) begin
            case (cmd.mslot) inside
                MS_X2, MS_Y2, MS_Z2: t2_reg <= rval[FRAC_BITS:0];
                MS_X3, MS_Y3, MS_Z3: t3_reg <= rval[FRAC_BITS:0];
                MS_XF:               fu_reg <= fclamp;
                MS_YF:               fv_reg <= fclamp;
                MS_ZF:               fw_reg <= fclamp;
                default:             lr_reg[lidx[2:0]] <= $signed(lsum[VW-1:0]);
            endcase
        end
    end

    // octave accumulation, weight 2^(MAX_OCTAVES - octave)
    logic signed [ACC_W-1:0] acc_reg;
    logic [WSH_W-1:0]        wsh_reg;
    logic signed [ACC_W-1:0] noise_ext;

    assign noise_ext = ACC_W'(lr_reg[6]);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cx_reg  <= coord_x_in;
            cy_reg  <= coord_y_in;
            cz_reg  <= coord_z_in;
            acc_reg <= '0;
            wsh_reg <= WSH_W'(MAX_OCTAVES);
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + (noise_ext <<< wsh_reg);
            wsh_reg <= WSH_W'(wsh_reg - 1'b1);
            cx_reg  <= {cx_reg[COORD_W-2:0], 1'b0};
            cy_reg  <= {cy_reg[COORD_W-2:0], 1'b0};
            cz_reg  <= {cz_reg[COORD_W-2:0], 1'b0};
        end
    end

    // map sum*0.5+0.5 to Q1.16 and clamp
    logic signed [ACC_W:0] acc2;
    logic [NW-1:0]         mag_w, scaled;
    logic [OUT_W-1:0]      num;
    logic [OUT_W-1:0]      noise_reg;
    logic                  out_valid_reg;

    assign acc2  = (ACC_W + 1)'(acc_reg) + $signed(BIAS);
    assign mag_w = NW'(acc2[ACC_W-1:0]);

    if (SH > 0) begin : g_round
        assign scaled = (mag_w + (NW'(1) << (SH - 1))) >> SH;
    end else begin : g_widen
        assign scaled = mag_w << (-SH);
    end

    always_comb begin
        if (acc2[ACC_W]) begin
            num = '0;
        end else if (scaled > OUT_ONE) begin
            num = OUT_ONE[OUT_W-1:0];
        end else begin
            num = scaled[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_en) begin
            noise_reg <= num;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.fin_en) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign noise_value     = noise_reg;
    assign status.out_busy = out_valid_reg & ~out_ready;

endmodule
`default_nettype wire

### sim/perlin_noise_3d_octaves_unit_test.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves_unit_test: self-checking bench for the octave noise unit
// Streams permutation loads and noise evaluations through the unit under
// random source gaps and sink stalls. It predicts every result word with a
// local fixed-point noise model and checks the results in order. The octave
// count is changed between phases, including zero and values above the
// maximum.
// ----------------------------------------------------------------------------
module perlin_noise_3d_octaves_unit_test;
    import pn3o_pkg::*;

    localparam int NOCT     = 8;
    localparam int FB       = 16;
    localparam longint ONE  = 64'sd1 <<< FB;
    localparam int LIMIT    = 10000000;

    typedef struct packed {
        logic        act;
        logic [23:0] cz;
        logic [23:0] cy;
        logic [23:0] cx;
        logic [7:0]  tval;
        logic [7:0]  tidx;
    } word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [OCT_CFG_W-1:0] cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;

    perlin_noise_3d_octaves_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [7:0] perm_bytes [256];
    logic [3:0] octaves_set;

    word_t       pending_words [$];
    logic [16:0] expected_noise [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          evals_sent = 0;
    int          loads_sent = 0;
    longint      cycle_count = 0;
    int          src_gap = 0;
    int          snk_stall = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint mul_rnd(longint a, longint b);
        return (a * b + (ONE >>> 1)) >>> FB;
    endfunction

    function automatic longint mul_rnd_signed(longint v, longint t);
        longint r;
        r = mul_rnd(v < 0 ? -v : v, t);
        return v < 0 ? -r : r;
    endfunction

    function automatic longint fade_of(longint t);
        longint t2, p, t3, f;
        t2 = mul_rnd(t, t);
        p  = 6 * t2 + 10 * ONE - 15 * t;
        t3 = mul_rnd(t2, t);
        f  = mul_rnd(t3, p);
        return f > ONE ? ONE : f;
    endfunction

    function automatic longint mix(longint t, longint a, longint b);
        return a + mul_rnd_signed(b - a, t);
    endfunction

    function automatic longint grad_dot(logic [7:0] hash, longint x, longint y, longint z);
        logic [3:0] h;
        longint u, v;
        h = hash[3:0];
        u = (h < HASH_U_Y) ? x : y;
        v = (h < HASH_V_ZX) ? y : ((h == HASH_V_X_A || h == HASH_V_X_B) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic [7:0] perm_at(int i);
        return perm_bytes[i & 255];
    endfunction

    function automatic longint noise_at(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
        int cxi, cyi, czi, a, aa, ab, b, ba, bb;
        longint x, y, z, u, v, w, l0, l1, l2, l3;
        cxi = px[23:16]; cyi = py[23:16]; czi = pz[23:16];
        x = px[15:0]; y = py[15:0]; z = pz[15:0];
        u = fade_of(x); v = fade_of(y); w = fade_of(z);
        a  = (perm_at(cxi) + cyi) & 255;
        aa = (perm_at(a) + czi) & 255;
        ab = (perm_at(a + 1) + czi) & 255;
        b  = (perm_at(cxi + 1) + cyi) & 255;
        ba = (perm_at(b) + czi) & 255;
        bb = (perm_at(b + 1) + czi) & 255;
        l0 = mix(u, grad_dot(perm_at(aa), x, y, z), grad_dot(perm_at(ba), x - ONE, y, z));
        l1 = mix(u, grad_dot(perm_at(ab), x, y - ONE, z),
                 grad_dot(perm_at(bb), x - ONE, y - ONE, z));
        l2 = mix(u, grad_dot(perm_at(aa + 1), x, y, z - ONE),
                 grad_dot(perm_at(ba + 1), x - ONE, y, z - ONE));
        l3 = mix(u, grad_dot(perm_at(ab + 1), x, y - ONE, z - ONE),
                 grad_dot(perm_at(bb + 1), x - ONE, y - ONE, z - ONE));
        return mix(w, mix(v, l0, l1), mix(v, l2, l3));
    endfunction

    function automatic logic [16:0] fbm_noise(word_t wd);
        logic [23:0] px, py, pz;
        longint acc, num;
        int n;
        px = wd.cx; py = wd.cy; pz = wd.cz;
        n = (octaves_set > NOCT) ? NOCT : octaves_set;
        acc = 0;
        for (int i = 0; i < n; i++) begin
            acc += noise_at(px, py, pz) * (64'sd1 <<< (NOCT - i));
            px = px << 1; py = py << 1; pz = pz << 1;
        end
        acc += 64'sd1 <<< (NOCT + FB);
        if (acc < 0) return '0;
        num = (acc + (64'sd1 <<< (NOCT + FB - 16))) >>> (NOCT + FB + 1 - 16);
        if (num > 65536) num = 65536;
        return num[16:0];
    endfunction

    // source driver
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (pending_words.size() > 0 && src_gap == 0) begin
                    word_t wd;
                    wd = pending_words.pop_front();
                    s_tdata  <= {8'd0, wd.cz, wd.cy, wd.cx, wd.tval, wd.tidx};
                    s_tuser  <= wd.act;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                end else if (pending_words.size() > 0) begin
                    word_t wd;
                    wd = pending_words.pop_front();
                    s_tdata  <= {8'd0, wd.cz, wd.cy, wd.cx, wd.tval, wd.tidx};
                    s_tuser  <= wd.act;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 2) == 0)
                        src_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                             : $urandom_range(1, 4);
                end
            end
        end
    end

    // accepted words feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tuser[0] == ACT_LOAD) begin
                perm_bytes[s_tdata[7:0]] = s_tdata[15:8];
                loads_sent++;
            end else begin
                word_t wd;
                wd.act = ACT_EVAL; wd.tidx = s_tdata[7:0]; wd.tval = s_tdata[15:8];
                wd.cx = s_tdata[39:16]; wd.cy = s_tdata[63:40]; wd.cz = s_tdata[87:64];
                expected_noise.push_back(fbm_noise(wd));
                evals_sent++;
            end
        end
    end

    // sink: random stalls, result check
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_noise.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    logic [16:0] want;
                    want = expected_noise.pop_front();
                    if (m_tdata[16:0] !== want || m_tdata[23:17] !== 7'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("noise mismatch: expected %0d, got %0d (word %h)",
                                     want, m_tdata[16:0], m_tdata);
                    end
                end
            end
            if (snk_stall > 0) begin
                snk_stall <= snk_stall - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                snk_stall <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 300)
                                                       : $urandom_range(1, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic word_t load_word(int idx, int val);
        word_t wd;
        wd = '0;
        wd.act = ACT_LOAD; wd.tidx = 8'(idx); wd.tval = 8'(val);
        wd.cx = 24'($urandom); wd.cy = 24'($urandom); wd.cz = 24'($urandom);
        return wd;
    endfunction

    function automatic word_t eval_word(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        word_t wd;
        wd.act = ACT_EVAL; wd.tidx = 8'($urandom); wd.tval = 8'($urandom);
        wd.cx = x; wd.cy = y; wd.cz = z;
        return wd;
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'hFFFFFF;
            1: return {8'($urandom_range(0, 255)), 16'h0000};
            2: return {8'($urandom_range(0, 255)), 16'hFFFF};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic drain_and_settle();
        while (pending_words.size() > 0 || s_tvalid || expected_noise.size() > 0)
            @(posedge aclk);
        // loads leave no result behind; let an in-flight evaluation finish
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_octaves(logic [3:0] n);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        octaves_set = n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int octave_plan [6] = '{8, 0, 15, 1, 3, 9};
        for (int i = 0; i < 256; i++) perm_bytes[i] = 8'(i);
        octaves_set = OCT_CFG_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: identity table, then three loaded bytes, at reset octave count, field extremes
        pending_words.push_back(eval_word(24'h000000, 24'h000000, 24'h000000));
        pending_words.push_back(eval_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        pending_words.push_back(eval_word(24'h008000, 24'h00FFFF, 24'h010000));
        pending_words.push_back(eval_word(24'hFF8000, 24'h7F4000, 24'h80C000));
        pending_words.push_back(load_word(0, 255));
        pending_words.push_back(load_word(255, 0));
        pending_words.push_back(load_word(128, 127));
        pending_words.push_back(eval_word(24'hFF0001, 24'h00FFFF, 24'hFFFFFF));
        pending_words.push_back(eval_word(24'h000001, 24'h800000, 24'h7FFFFF));
        for (int i = 0; i < 4; i++)
            pending_words.push_back(eval_word(24'($urandom), 24'($urandom), 24'($urandom)));
        drain_and_settle();

        for (int ph = 0; ph < 6; ph++) begin
            int n_items;
            write_octaves(4'(octave_plan[ph]));
            // settings with many octaves get fewer items to keep the run short
            n_items = (octave_plan[ph] > 4) ? 80 : 200;
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // reload a burst of the table with random bytes
                    int base;
                    int burst;
                    base = $urandom_range(0, 255);
                    burst = $urandom_range(1, 8);
                    for (int j = 0; j < burst; j++)
                        pending_words.push_back(load_word((base + j) & 255, $urandom));
                end else begin
                    pending_words.push_back(eval_word(rand_coord(), rand_coord(), rand_coord()));
                end
            end
            drain_and_settle();
        end

        $display("covered %0d evaluations and %0d table loads over seven octave settings",
                 evals_sent, loads_sent);
        $display("%0d result words checked", results_seen);
        if (mismatches == 0 && expected_noise.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_noise.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
